// ===== src/varf_pkg.sv =====
// Package for the VAR forecast recursion engine: sizes, request and register
// codes, controller states and the lane control bundle.
// No dependencies; every other file of the block depends on it.
package varf_pkg;

  // Table sizes
  localparam int MAX_VARS       = 8;
  localparam int MAX_LAGS       = 8;
  localparam int MAX_REGRESSORS = 65;
  localparam int RESULT_CAP     = 8;
  localparam int VARS_LIMIT     = (MAX_VARS < RESULT_CAP) ? MAX_VARS : RESULT_CAP;

  // Field widths
  localparam int REQ_W   = 2;
  localparam int ROW_W   = 7;
  localparam int COL_W   = 3;
  localparam int VAL_W   = 32;
  localparam int VIDX_W  = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W   = 4;

  // Exact sum of MAX_REGRESSORS products of two 32-bit values
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_REGRESSORS) + 1;
  localparam int FRAC_W = 16;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_COEF = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LAG  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STEP = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_VARS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_LAGS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_CONST = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_SHIFT,
    ST_SHDRAIN,
    ST_FILL
  } state_t;

  // Control shared by all MAC lanes
  typedef struct packed {
    logic             rd_en;
    logic [ROW_W-1:0] rd_addr;
    logic             mul_en;
    logic             acc_clr;
    logic             acc_en;
    logic             res_ld;
  } lane_ctrl_t;

endpackage

// ===== src/varf_if.sv =====
// Valid/ready channels of the VAR forecast engine: request in, forecast out.
// Depends on varf_pkg for field widths.
interface varf_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [varf_pkg::REQ_W-1:0]           req_type;
  logic [varf_pkg::ROW_W-1:0]           row;
  logic [varf_pkg::COL_W-1:0]           col;
  logic signed [varf_pkg::VAL_W-1:0]    value;

  modport source (output valid, req_type, row, col, value, input ready);
  modport sink   (input valid, req_type, row, col, value, output ready);
endinterface

interface varf_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [varf_pkg::VIDX_W-1:0]          var_index;
  logic signed [varf_pkg::VAL_W-1:0]    forecast;
  logic                                 saturated;
  logic                                 last;

  modport source (output valid, var_index, forecast, saturated, last, input ready);
  modport sink   (input valid, var_index, forecast, saturated, last, output ready);
endinterface

// ===== src/varf_lane.sv =====
// One MAC lane: holds one coefficient column in a synchronous memory,
// multiplies it by the broadcast lag value, accumulates, rounds and saturates.
// Depends on varf_pkg.
module varf_lane (
  input  logic                               clk,
  input  varf_pkg::lane_ctrl_t               ctrl,
  input  logic                               wr_en,
  input  logic [varf_pkg::ROW_W-1:0]         wr_addr,
  input  logic signed [varf_pkg::VAL_W-1:0]  wr_data,
  input  logic signed [varf_pkg::VAL_W-1:0]  lag_q,
  output logic signed [varf_pkg::VAL_W-1:0]  res,
  output logic                               sat
);
  import varf_pkg::*;

  localparam int Q_W = ACC_W - FRAC_W;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (FRAC_W - 1));

  logic signed [VAL_W-1:0]  coef_mem [MAX_REGRESSORS];
  logic signed [VAL_W-1:0]  coef_q_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [VAL_W-1:0]  res_r;
  logic                     sat_r;

  logic signed [ACC_W-1:0]  rnd;
  logic [Q_W-1:0]           q;
  logic                     ovf;
  logic signed [VAL_W-1:0]  clip;

  // Coefficient column: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      coef_mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      coef_q_r <= coef_mem[ctrl.rd_addr];
    end
  end

  // Multiply, then accumulate
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= PROD_W'(lag_q) * PROD_W'(coef_q_r);
    end
    if (ctrl.acc_clr) begin
      acc_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // Round half up to Q16.16, clip to the 32-bit range
  always_comb begin
    rnd  = acc_r + RND_HALF;
    q    = rnd[ACC_W-1:FRAC_W];
    ovf  = !((&q[Q_W-1:VAL_W-1]) || !(|q[Q_W-1:VAL_W-1]));
    if (ovf) begin
      clip = q[Q_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      clip = q[VAL_W-1:0];
    end
  end

  // Hold the result until the next step finishes its sums
  always_ff @(posedge clk) begin
    if (ctrl.res_ld) begin
      res_r <= clip;
      sat_r <= ovf;
    end
  end

  assign res = res_r;
  assign sat = sat_r;

endmodule

// ===== src/var_forecast_recursion.sv =====
// VAR forecast recursion engine, top level: controller, lag memory, MAC lanes
// and the result register. Depends on varf_pkg, varf_if and varf_lane.
//
// Coefficient and lag loads are each written as they are accepted. A step
// has K = has_constant + num_vars * num_lags regressors, M = num_vars and
// S = K - M - has_constant lag entries that move one block older (no shift
// when S = 0): the lag memory's single read port serves the MAC walk over
// the K regressors (all variables in parallel lanes) and then the shift of
// the S entries, its single write port the storing of the M new forecasts.
// Results leave through an output register at one per cycle, while the
// receiver is ready, as the lag update goes on; a following step rounds its
// sums only once the previous step's results have all been loaded into the
// output register. Memories hold no reset value.
module var_forecast_recursion (
  input  logic                                clk,
  input  logic                                rst_n,
  varf_in_if.sink                             in_chan,
  varf_out_if.source                          out_chan,
  input  logic                                cfg_we,
  input  logic [varf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [varf_pkg::CFG_W-1:0]          cfg_wdata
);
  import varf_pkg::*;

  localparam logic [CFG_W-1:0] VARS_MAX_C = CFG_W'(VARS_LIMIT);
  localparam logic [CFG_W-1:0] LAGS_MAX_C = CFG_W'(MAX_LAGS);
  localparam logic [ROW_W-1:0] ROWS_C     = ROW_W'(MAX_REGRESSORS);

  // Configuration registers
  logic [CFG_W-1:0] num_vars_r;
  logic [CFG_W-1:0] num_lags_r;
  logic             has_const_r;

  function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Take register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vars_r  <= CFG_W'(1);
      num_lags_r  <= CFG_W'(1);
      has_const_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_VARS:  num_vars_r  <= clamp_cfg(cfg_wdata, VARS_MAX_C);
        CFG_NUM_LAGS:  num_lags_r  <= clamp_cfg(cfg_wdata, LAGS_MAX_C);
        CFG_HAS_CONST: has_const_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Controller registers
  state_t           state_r, state_nxt;
  logic [ROW_W-1:0] k_r;
  logic [ROW_W-1:0] rd_cnt_r;
  logic [ROW_W-1:0] src_r;
  logic [VIDX_W-1:0] fill_r;
  logic             rdv_r;
  logic             prodv_r;
  logic             sh_v_r;
  logic [ROW_W-1:0] sh_dst_r;

  // Result path registers
  logic              emit_busy_r;
  logic [VIDX_W-1:0] emit_idx_r;
  logic              out_valid_r;
  logic [VIDX_W-1:0] out_vidx_r;
  logic signed [VAL_W-1:0] out_fc_r;
  logic              out_sat_r;
  logic              out_last_r;

  // Lag memory
  logic signed [VAL_W-1:0] lag_mem [MAX_REGRESSORS];
  logic signed [VAL_W-1:0] lag_q_r;
  logic                    lag_rd_en;
  logic [ROW_W-1:0]        lag_rd_addr;
  logic                    lag_we;
  logic [ROW_W-1:0]        lag_waddr;
  logic signed [VAL_W-1:0] lag_wdata;

  // Lanes
  lane_ctrl_t              lane_ctrl;
  logic signed [VAL_W-1:0] lane_res [MAX_VARS];
  logic                    lane_sat [MAX_VARS];

  logic             in_xfer;
  logic             step_xfer;
  logic             round_go;
  logic [ROW_W-1:0] m_ext;
  logic [ROW_W-1:0] mk;
  logic [ROW_W-1:0] k_nxt;
  logic [2*CFG_W-1:0] ml;
  logic             row_ok;
  logic             emit_load;
  logic             emit_last;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer   = in_chan.valid && in_chan.ready;
  assign step_xfer = in_xfer && (in_chan.req_type == REQ_STEP);
  assign row_ok    = (in_chan.row < ROWS_C);
  assign round_go  = (state_r == ST_ROUND) && !emit_busy_r;

  assign m_ext = ROW_W'(num_vars_r);
  assign mk    = m_ext + ROW_W'(has_const_r);
  assign ml    = (2*CFG_W)'(num_vars_r) * (2*CFG_W)'(num_lags_r);

  // Regressor count of a step, capped at the table depth
  always_comb begin
    k_nxt = ROW_W'(ml) + ROW_W'(has_const_r);
    if (k_nxt > ROWS_C) begin
      k_nxt = ROWS_C;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (step_xfer) state_nxt = ST_MAC;
      end
      ST_MAC: begin
        if (rd_cnt_r == k_r - ROW_W'(1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!rdv_r && !prodv_r) state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (!emit_busy_r) state_nxt = (k_r > mk) ? ST_SHIFT : ST_FILL;
      end
      ST_SHIFT: begin
        if (src_r == ROW_W'(has_const_r)) state_nxt = ST_SHDRAIN;
      end
      ST_SHDRAIN: begin
        state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (CFG_W'(fill_r) == num_vars_r - CFG_W'(1)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    lag_rd_en   = 1'b0;
    lag_rd_addr = rd_cnt_r;
    lane_ctrl   = '0;
    lane_ctrl.rd_addr = rd_cnt_r;
    lane_ctrl.mul_en  = rdv_r;
    lane_ctrl.acc_en  = prodv_r;
    lane_ctrl.acc_clr = step_xfer;
    lane_ctrl.res_ld  = round_go;
    case (state_r)
      ST_MAC: begin
        lag_rd_en        = 1'b1;
        lane_ctrl.rd_en  = 1'b1;
      end
      ST_SHIFT: begin
        lag_rd_en   = 1'b1;
        lag_rd_addr = src_r;
      end
      default: ;
    endcase
  end

  // Lag memory write source: load, shift move, then new forecasts
  always_comb begin
    lag_we    = 1'b0;
    lag_waddr = in_chan.row;
    lag_wdata = in_chan.value;
    if (in_xfer && (in_chan.req_type == REQ_LAG) && row_ok) begin
      lag_we = 1'b1;
    end else if (sh_v_r) begin
      lag_we    = 1'b1;
      lag_waddr = sh_dst_r;
      lag_wdata = lag_q_r;
    end else if (state_r == ST_FILL) begin
      lag_we    = 1'b1;
      lag_waddr = ROW_W'(has_const_r) + ROW_W'(fill_r);
      lag_wdata = lane_res[fill_r];
    end
  end

  // Lag memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (lag_we) begin
      lag_mem[lag_waddr] <= lag_wdata;
    end
    if (lag_rd_en) begin
      lag_q_r <= lag_mem[lag_rd_addr];
    end
  end

  // Controller state and pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rdv_r   <= 1'b0;
      prodv_r <= 1'b0;
      sh_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rdv_r   <= (state_r == ST_MAC);
      prodv_r <= rdv_r;
      sh_v_r  <= (state_r == ST_SHIFT);
    end
  end

  // Walk counters; the shift starts at the oldest source entry, K - M - 1
  always_ff @(posedge clk) begin
    sh_dst_r <= src_r + m_ext;
    case (state_r)
      ST_IDLE: begin
        if (step_xfer) begin
          k_r      <= k_nxt;
          rd_cnt_r <= '0;
        end
      end
      ST_MAC: rd_cnt_r <= rd_cnt_r + ROW_W'(1);
      ST_ROUND: begin
        src_r  <= k_r - m_ext - ROW_W'(1);
        fill_r <= '0;
      end
      ST_SHIFT: src_r  <= src_r - ROW_W'(1);
      ST_FILL:  fill_r <= fill_r + VIDX_W'(1);
      default: ;
    endcase
  end

  // Coefficient columns, one lane per variable
  for (genvar i = 0; i < MAX_VARS; i++) begin : g_lane
    logic wr_en;
    assign wr_en = in_xfer && (in_chan.req_type == REQ_COEF) && row_ok &&
                   (in_chan.col == COL_W'(i));
    varf_lane u_lane (
      .clk     (clk),
      .ctrl    (lane_ctrl),
      .wr_en   (wr_en),
      .wr_addr (in_chan.row),
      .wr_data (in_chan.value),
      .lag_q   (lag_q_r),
      .res     (lane_res[i]),
      .sat     (lane_sat[i])
    );
  end

  // Send the forecasts one per transfer through the output register
  assign emit_load = emit_busy_r && (!out_valid_r || out_chan.ready);
  assign emit_last = (CFG_W'(emit_idx_r) == num_vars_r - CFG_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_busy_r <= 1'b0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (round_go) begin
        emit_busy_r <= 1'b1;
        emit_idx_r  <= '0;
      end else if (emit_load) begin
        emit_idx_r <= emit_idx_r + VIDX_W'(1);
        if (emit_last) emit_busy_r <= 1'b0;
      end
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_vidx_r <= emit_idx_r;
      out_fc_r   <= lane_res[emit_idx_r];
      out_sat_r  <= lane_sat[emit_idx_r];
      out_last_r <= emit_last;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.var_index = out_vidx_r;
  assign out_chan.forecast  = out_fc_r;
  assign out_chan.saturated = out_sat_r;
  assign out_chan.last      = out_last_r;

endmodule
